// ===== hdl/sta_pkg.sv =====
package sta_pkg;

  localparam int NUM_TAGS    = 255;
  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;

  localparam int TAG_W    = 8;
  localparam int STATUS_W = 3;

  localparam logic [TAG_W-1:0] PTR_NONE = 8'hFF;
  localparam logic [TAG_W-1:0] MAX_TAG  = 8'hFE;

  // free map is searched in groups of GRP_SZ tags
  localparam int OFF_W  = 4;
  localparam int GRP_SZ = 1 << OFF_W;
  localparam int GRP_N  = (NUM_TAGS + GRP_SZ - 1) / GRP_SZ;
  localparam int GRP_W  = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int MAP_W  = GRP_N * GRP_SZ;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // result status codes
  localparam logic [STATUS_W-1:0] STS_SENT      = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EVENT     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_QUEUED    = 3'd2;
  localparam logic [STATUS_W-1:0] STS_DROPPED   = 3'd3;
  localparam logic [STATUS_W-1:0] STS_DONE      = 3'd4;
  localparam logic [STATUS_W-1:0] STS_UNMATCHED = 3'd5;

  // command kinds from the front classifier
  localparam logic [1:0] CMD_SEND   = 2'd0;
  localparam logic [1:0] CMD_EVENT  = 2'd1;
  localparam logic [1:0] CMD_REPLY  = 2'd2;
  localparam logic [1:0] CMD_BADTAG = 2'd3;

  typedef struct packed {
    logic [1:0]             kind;
    logic [HANDLE_BITS-1:0] handle;
    logic [TAG_W-1:0]       rtag;
  } cmd_t;

  typedef struct packed {
    logic             go;
    logic [TAG_W-1:0] start;
  } srch_req_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } srch_rsp_t;

endpackage

// ===== hdl/sta_front.sv =====
module sta_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [sta_pkg::HANDLE_BITS-1:0] in_request_id,
  input  logic                            in_is_event,
  input  logic [sta_pkg::TAG_W-1:0]       in_reply_tag,
  output logic                            cmd_valid,
  output sta_pkg::cmd_t                   cmd_head,
  input  logic                            cmd_pop
);
  import sta_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       in_cmd;
  logic       push;

  // classify the incoming item
  always_comb begin
    in_cmd.handle = in_request_id;
    in_cmd.rtag   = in_reply_tag;
    if (!in_func) begin
      in_cmd.kind = in_is_event ? CMD_EVENT : CMD_SEND;
    end else if (in_reply_tag > MAX_TAG || in_reply_tag >= TAG_W'(NUM_TAGS)) begin
      in_cmd.kind = CMD_BADTAG;
    end else begin
      in_cmd.kind = CMD_REPLY;
    end
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ===== hdl/sta_search.sv =====
module sta_search (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sta_pkg::srch_req_t        req,
  input  logic [sta_pkg::MAP_W-1:0] free_map,
  output sta_pkg::srch_rsp_t        rsp
);
  import sta_pkg::*;

  logic [GRP_N-1:0]  gne;
  logic [GRP_W-1:0]  sg;
  logic [OFF_W-1:0]  so;
  logic [GRP_SZ-1:0] grp_bits;
  logic              hit_self;
  logic              fwd_found, wrap_found;
  logic [GRP_W-1:0]  fwd_grp, wrap_grp;

  logic              s1_valid_r;
  logic              s1_found_r, s1_found_nxt;
  logic              s1_mask_r, s1_mask_nxt;
  logic [GRP_W-1:0]  s1_grp_r, s1_grp_nxt;
  logic [OFF_W-1:0]  s1_off_r;

  logic [GRP_SZ-1:0] s2_bits;
  logic [OFF_W-1:0]  s2_off;

  assign sg       = req.start[OFF_W +: GRP_W];
  assign so       = req.start[OFF_W-1:0];
  assign grp_bits = free_map[{sg, {OFF_W{1'b0}}} +: GRP_SZ];
  assign hit_self = |(grp_bits & ({GRP_SZ{1'b1}} << so));

  // first stage: pick the group that holds the next free tag
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      gne[g] = |free_map[g*GRP_SZ +: GRP_SZ];
    end
  end

  always_comb begin
    fwd_found  = 1'b0;
    fwd_grp    = '0;
    wrap_found = 1'b0;
    wrap_grp   = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (gne[g] && GRP_W'(g) > sg) begin
        fwd_found = 1'b1;
        fwd_grp   = GRP_W'(g);
      end
      if (gne[g] && GRP_W'(g) <= sg) begin
        wrap_found = 1'b1;
        wrap_grp   = GRP_W'(g);
      end
    end
  end

  always_comb begin
    s1_found_nxt = hit_self || fwd_found || wrap_found;
    s1_mask_nxt  = hit_self;
    if (hit_self) begin
      s1_grp_nxt = sg;
    end else if (fwd_found) begin
      s1_grp_nxt = fwd_grp;
    end else begin
      s1_grp_nxt = wrap_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req.go;
    end
  end

  always_ff @(posedge clk) begin
    s1_found_r <= s1_found_nxt;
    s1_mask_r  <= s1_mask_nxt;
    s1_grp_r   <= s1_grp_nxt;
    s1_off_r   <= so;
  end

  // second stage: lowest free tag inside the chosen group, at or above the start offset in the start's own group
  assign s2_bits = free_map[{s1_grp_r, {OFF_W{1'b0}}} +: GRP_SZ] &
                   (s1_mask_r ? ({GRP_SZ{1'b1}} << s1_off_r) : {GRP_SZ{1'b1}});

  always_comb begin
    s2_off = '0;
    for (int b = GRP_SZ - 1; b >= 0; b--) begin
      if (s2_bits[b]) begin
        s2_off = OFF_W'(b);
      end
    end
  end

  assign rsp.valid = s1_valid_r;
  assign rsp.tag   = s1_found_r ? TAG_W'({s1_grp_r, s2_off}) : PTR_NONE;

endmodule

// ===== hdl/sta_back.sv =====
module sta_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  sta_pkg::cmd_t                   cmd_head,
  output logic                            cmd_pop,
  output sta_pkg::srch_req_t              srch_req,
  input  sta_pkg::srch_rsp_t              srch_rsp,
  output logic [sta_pkg::MAP_W-1:0]       free_map,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sta_pkg::STATUS_W-1:0]    out_status,
  output logic [sta_pkg::TAG_W-1:0]       out_tag,
  output logic [sta_pkg::HANDLE_BITS-1:0] out_handle_out,
  output logic                            out_last
);
  import sta_pkg::*;

  localparam logic [2:0] S_EXEC   = 3'd0;
  localparam logic [2:0] S_RESEND = 3'd1;
  localparam logic [2:0] S_DONE   = 3'd2;
  localparam logic [2:0] S_SRCH   = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;

  localparam int SUM_W = QCNT_W + 1;
  localparam logic [MAP_W-1:0] MAP_RST = {MAP_W{1'b1}} >> (MAP_W - NUM_TAGS);

  logic [2:0]             state_r, state_nxt;
  logic [TAG_W-1:0]       ptr_r, ptr_nxt;
  logic [MAP_W-1:0]       free_map_r, map_nxt;
  logic [QPTR_W-1:0]      qhead_r, qhead_nxt;
  logic [QCNT_W-1:0]      qcnt_r, qcnt_nxt;
  logic [TAG_W-1:0]       rtag_r, rtag_nxt;
  logic [TAG_W-1:0]       start_r, start_nxt;
  logic [HANDLE_BITS-1:0] w_handle_r;
  logic                   w_event_r;

  logic [HANDLE_BITS-1:0] wq_handle_r [QUEUE_DEPTH];
  logic                   wq_event_r  [QUEUE_DEPTH];
  logic [SUM_W-1:0]       tail_sum;
  logic [QPTR_W-1:0]      tail;
  logic                   wq_push, wq_pop;

  logic [HANDLE_BITS-1:0] hmem [NUM_TAGS];
  logic [HANDLE_BITS-1:0] rd_handle_r;
  logic                   mem_we, mem_re;
  logic [TAG_W-1:0]       mem_addr;
  logic [HANDLE_BITS-1:0] mem_wd;

  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    out_status_r;
  logic [TAG_W-1:0]       out_tag_r;
  logic [HANDLE_BITS-1:0] out_handle_r;
  logic                   out_last_r;

  logic                   can_load, emit, go;
  logic [STATUS_W-1:0]    e_status;
  logic [TAG_W-1:0]       e_tag;
  logic [HANDLE_BITS-1:0] e_handle;
  logic                   e_last;

  assign can_load = !out_valid_r || out_ready;

  assign tail_sum = SUM_W'(qhead_r) + SUM_W'(qcnt_r);
  assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    QPTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : QPTR_W'(tail_sum);

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    map_nxt   = free_map_r;
    qhead_nxt = qhead_r;
    qcnt_nxt  = qcnt_r;
    rtag_nxt  = rtag_r;
    start_nxt = start_r;
    cmd_pop   = 1'b0;
    wq_push   = 1'b0;
    wq_pop    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cmd_head.rtag;
    mem_wd    = cmd_head.handle;
    emit      = 1'b0;
    e_status  = STS_SENT;
    e_tag     = '0;
    e_handle  = '0;
    e_last    = 1'b1;
    go        = 1'b0;
    case (state_r)
      S_EXEC: begin
        if (cmd_valid && can_load) begin
          cmd_pop  = 1'b1;
          rtag_nxt = cmd_head.rtag;
          case (cmd_head.kind)
            CMD_SEND, CMD_EVENT: begin
              emit     = 1'b1;
              e_handle = cmd_head.handle;
              if (ptr_r == PTR_NONE) begin
                // no tag free: park it or drop it
                if (qcnt_r < QCNT_W'(QUEUE_DEPTH)) begin
                  wq_push  = 1'b1;
                  qcnt_nxt = qcnt_r + QCNT_W'(1);
                  e_status = STS_QUEUED;
                end else begin
                  e_status = STS_DROPPED;
                end
              end else begin
                e_tag     = ptr_r;
                start_nxt = (ptr_r == TAG_W'(NUM_TAGS - 1)) ? '0 : ptr_r + TAG_W'(1);
                state_nxt = S_SRCH;
                if (cmd_head.kind == CMD_SEND) begin
                  e_status       = STS_SENT;
                  map_nxt[ptr_r] = 1'b0;
                  mem_we         = 1'b1;
                  mem_addr       = ptr_r;
                end else begin
                  e_status = STS_EVENT;
                end
              end
            end
            CMD_REPLY: begin
              if (free_map_r[cmd_head.rtag]) begin
                emit     = 1'b1;
                e_status = STS_UNMATCHED;
                e_tag    = cmd_head.rtag;
              end else begin
                mem_re                 = 1'b1;
                map_nxt[cmd_head.rtag] = 1'b1;
                state_nxt              = S_DONE;
                // release that ends exhaustion
                if (ptr_r == PTR_NONE) begin
                  ptr_nxt = cmd_head.rtag;
                  if (qcnt_r != '0) begin
                    wq_pop    = 1'b1;
                    qhead_nxt = (qhead_r == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                '0 : qhead_r + QPTR_W'(1);
                    qcnt_nxt  = qcnt_r - QCNT_W'(1);
                    state_nxt = S_RESEND;
                  end
                end
              end
            end
            default: begin
              emit     = 1'b1;
              e_status = STS_UNMATCHED;
              e_tag    = cmd_head.rtag;
            end
          endcase
        end
      end
      S_RESEND: begin
        if (can_load) begin
          emit      = 1'b1;
          e_tag     = rtag_r;
          e_handle  = w_handle_r;
          e_last    = 1'b0;
          state_nxt = S_DONE;
          if (w_event_r) begin
            e_status = STS_EVENT;
          end else begin
            e_status        = STS_SENT;
            map_nxt[rtag_r] = 1'b0;
            mem_we          = 1'b1;
            mem_addr        = rtag_r;
            mem_wd          = w_handle_r;
            ptr_nxt         = PTR_NONE;
          end
        end
      end
      S_DONE: begin
        if (can_load) begin
          emit      = 1'b1;
          e_status  = STS_DONE;
          e_tag     = rtag_r;
          e_handle  = rd_handle_r;
          state_nxt = S_EXEC;
        end
      end
      S_SRCH: begin
        go        = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (srch_rsp.valid) begin
          ptr_nxt   = srch_rsp.tag;
          state_nxt = S_EXEC;
        end
      end
      default: begin
        state_nxt = S_EXEC;
      end
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      ptr_r       <= '0;
      free_map_r  <= MAP_RST;
      qhead_r     <= '0;
      qcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      free_map_r  <= map_nxt;
      qhead_r     <= qhead_nxt;
      qcnt_r      <= qcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rtag_r  <= rtag_nxt;
    start_r <= start_nxt;
    if (wq_push) begin
      wq_handle_r[tail] <= cmd_head.handle;
      wq_event_r[tail]  <= (cmd_head.kind == CMD_EVENT);
    end
    if (wq_pop) begin
      w_handle_r <= wq_handle_r[qhead_r];
      w_event_r  <= wq_event_r[qhead_r];
    end
    if (emit) begin
      out_status_r <= e_status;
      out_tag_r    <= e_tag;
      out_handle_r <= e_handle;
      out_last_r   <= e_last;
    end
  end

  // in-flight handle table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hmem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_handle_r <= hmem[mem_addr];
    end
  end

  assign srch_req.go    = go;
  assign srch_req.start = start_r;
  assign free_map       = free_map_r;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_tag        = out_tag_r;
  assign out_handle_out = out_handle_r;
  assign out_last       = out_last_r;

endmodule

// ===== hdl/sequence_tag_allocator_core.sv =====
// an accepted item waits in the command queue, then is registered into the result register
// a send with a free tag passes through execute, then the 2-stage next-free search
// a queued, dropped or unmatched item needs execute alone, an ordinary release execute then done
// a release that ends exhaustion and resends a waiting item passes through execute, resend and done
// reset: every tag free, pointer at tag 0, wait queue and command queue empty
// tag table and wait queue contents are not cleared and are only read after being written
module sequence_tag_allocator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [sta_pkg::HANDLE_BITS-1:0] in_request_id,
  input  logic                            in_is_event,
  input  logic [sta_pkg::TAG_W-1:0]       in_reply_tag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sta_pkg::STATUS_W-1:0]    out_status,
  output logic [sta_pkg::TAG_W-1:0]       out_tag,
  output logic [sta_pkg::HANDLE_BITS-1:0] out_handle_out,
  output logic                            out_last
);
  import sta_pkg::*;

  logic             cmd_valid;
  cmd_t             cmd_head;
  logic             cmd_pop;
  srch_req_t        srch_req;
  srch_rsp_t        srch_rsp;
  logic [MAP_W-1:0] free_map;

  sta_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_request_id (in_request_id),
    .in_is_event   (in_is_event),
    .in_reply_tag  (in_reply_tag),
    .cmd_valid     (cmd_valid),
    .cmd_head      (cmd_head),
    .cmd_pop       (cmd_pop)
  );

  sta_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (srch_req),
    .free_map (free_map),
    .rsp      (srch_rsp)
  );

  sta_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_head       (cmd_head),
    .cmd_pop        (cmd_pop),
    .srch_req       (srch_req),
    .srch_rsp       (srch_rsp),
    .free_map       (free_map),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_tag        (out_tag),
    .out_handle_out (out_handle_out),
    .out_last       (out_last)
  );

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result register valid after reset");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command queue popped while empty");

  a_search_latency: assert property (@(posedge clk) disable iff (!rst_n)
    srch_req.go |=> srch_rsp.valid)
    else $error("next-free search did not answer in one cycle");

  a_resend_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (out_valid && out_status == STS_DONE))
    else $error("resend item not followed by its completion");

endmodule
